// ===== src/dpfc_pkg.sv =====
`timescale 1ns / 1ps

package dpfc_pkg;

  localparam int STEP_W = 4;
  localparam int COND_W = 4;
  localparam int OP_W = 3;
  localparam int COUNT_W = 4;

  typedef logic [STEP_W-1:0] step_t;

  // Jump conditions
  localparam logic [COND_W-1:0] C_NEVER    = 4'd0;
  localparam logic [COND_W-1:0] C_ALWAYS   = 4'd1;
  localparam logic [COND_W-1:0] C_IN_NONE  = 4'd2;
  localparam logic [COND_W-1:0] C_N_LT2    = 4'd3;
  localparam logic [COND_W-1:0] C_N_ODD    = 4'd4;
  localparam logic [COND_W-1:0] C_N1_ZERO  = 4'd5;
  localparam logic [COND_W-1:0] C_DIV_BUSY = 4'd6;
  localparam logic [COND_W-1:0] C_D_GT_Q   = 4'd7;
  localparam logic [COND_W-1:0] C_R_NZ     = 4'd8;
  localparam logic [COND_W-1:0] C_R_ZERO   = 4'd9;
  localparam logic [COND_W-1:0] C_OUT_FULL = 4'd10;

  // Datapath operations
  localparam logic [OP_W-1:0] OP_NONE    = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD    = 3'd1;
  localparam logic [OP_W-1:0] OP_HALVE   = 3'd2;
  localparam logic [OP_W-1:0] OP_START   = 3'd3;
  localparam logic [OP_W-1:0] OP_TAKE_Q  = 3'd4;
  localparam logic [OP_W-1:0] OP_NEXT_D  = 3'd5;
  localparam logic [OP_W-1:0] OP_PUBLISH = 3'd6;

  // Program addresses
  localparam step_t S_IDLE     = 4'd0;
  localparam step_t S_SMALL    = 4'd1;
  localparam step_t S_EVEN     = 4'd2;
  localparam step_t S_HALVE    = 4'd3;
  localparam step_t S_TRY      = 4'd4;
  localparam step_t S_TRY_WAIT = 4'd5;
  localparam step_t S_BOUND    = 4'd6;
  localparam step_t S_DIVIDES  = 4'd7;
  localparam step_t S_REDUCE   = 4'd8;
  localparam step_t S_RED_DIV  = 4'd9;
  localparam step_t S_RED_WAIT = 4'd10;
  localparam step_t S_RED_TEST = 4'd11;
  localparam step_t S_NEXT     = 4'd12;
  localparam step_t S_FINAL    = 4'd13;
  localparam step_t S_PUBLISH  = 4'd14;
  localparam step_t S_RETURN   = 4'd15;

  // gated: op and count increment only take effect when the jump is not taken
  typedef struct packed {
    logic [COND_W-1:0] cond;
    step_t             target;
    logic [OP_W-1:0]   op;
    logic              inc;
    logic              gated;
  } ctrl_t;

  function automatic ctrl_t ucode(input step_t step);
    ctrl_t w;
    w = '{cond: C_NEVER, target: S_IDLE, op: OP_NONE, inc: 1'b0, gated: 1'b0};
    unique case (step)
      S_IDLE:     w = '{C_IN_NONE,  S_IDLE,     OP_LOAD,    1'b0, 1'b1};
      S_SMALL:    w = '{C_N_LT2,    S_FINAL,    OP_NONE,    1'b0, 1'b0};
      S_EVEN:     w = '{C_N_ODD,    S_TRY,      OP_NONE,    1'b1, 1'b1};
      S_HALVE:    w = '{C_N1_ZERO,  S_HALVE,    OP_HALVE,   1'b0, 1'b0};
      S_TRY:      w = '{C_NEVER,    S_IDLE,     OP_START,   1'b0, 1'b0};
      S_TRY_WAIT: w = '{C_DIV_BUSY, S_TRY_WAIT, OP_NONE,    1'b0, 1'b0};
      S_BOUND:    w = '{C_D_GT_Q,   S_FINAL,    OP_NONE,    1'b0, 1'b0};
      S_DIVIDES:  w = '{C_R_NZ,     S_NEXT,     OP_NONE,    1'b1, 1'b1};
      S_REDUCE:   w = '{C_NEVER,    S_IDLE,     OP_TAKE_Q,  1'b0, 1'b0};
      S_RED_DIV:  w = '{C_NEVER,    S_IDLE,     OP_START,   1'b0, 1'b0};
      S_RED_WAIT: w = '{C_DIV_BUSY, S_RED_WAIT, OP_NONE,    1'b0, 1'b0};
      S_RED_TEST: w = '{C_R_ZERO,   S_REDUCE,   OP_NONE,    1'b0, 1'b0};
      S_NEXT:     w = '{C_ALWAYS,   S_TRY,      OP_NEXT_D,  1'b0, 1'b0};
      S_FINAL:    w = '{C_N_LT2,    S_PUBLISH,  OP_NONE,    1'b1, 1'b1};
      S_PUBLISH:  w = '{C_OUT_FULL, S_PUBLISH,  OP_PUBLISH, 1'b0, 1'b1};
      S_RETURN:   w = '{C_ALWAYS,   S_IDLE,     OP_NONE,    1'b0, 1'b0};
      default:    w = '{C_ALWAYS,   S_IDLE,     OP_NONE,    1'b0, 1'b0};
    endcase
    return w;
  endfunction

endpackage

// ===== src/dpfc_div.sv =====
`timescale 1ns / 1ps

module dpfc_div #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int CNT_W = $clog2(W + 1);

  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     quo;
  logic [W-1:0]     rem;
  logic [W-1:0]     dsr;
  logic [W:0]       rem_shift;
  logic [W:0]       rem_sub;
  logic             fits;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_shift = {rem, quo[W-1]};
    fits      = rem_shift >= {1'b0, dsr};
    rem_sub   = rem_shift - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(W);
      quo  <= dividend;
      rem  <= '0;
      dsr  <= divisor;
    end else if (busy) begin
      quo <= {quo[W-2:0], fits};
      rem <= fits ? rem_sub[W-1:0] : rem_shift[W-1:0];
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ===== src/distinct_prime_factor_count.sv =====
`timescale 1ns / 1ps
// Distinct prime factor counter, trial division.
// Input channel: value with in_valid / in_ready; one transaction is one integer
// (its low VALUE_WIDTH bits are used). Output channel: prime_count with
// out_valid / out_ready; exactly one result per input, in order.
// A small microprogram drives the datapath: factors of two are stripped by
// shifting, then odd candidates d = 3, 5, 7, ... are tried while d <= n / d.
// Every division runs on one shared restoring divider, which sets the pace: the
// sequencer waits while it is busy, once per odd candidate and again in the loop
// that divides out each factor found. One item is handled at a time; in_ready
// is high only while the sequencer is idle.
// The result sits in an output register; the next value is accepted while it
// waits, and the sequencer holds at its publish step if the receiver stalls
// with a result still pending.
// Reset (synchronous, active high) returns the sequencer to idle and drops
// out_valid; nothing else needs clearing.
module distinct_prime_factor_count #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [31:0]                    value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [dpfc_pkg::COUNT_W-1:0]   prime_count
);

  import dpfc_pkg::*;

  localparam int W = VALUE_WIDTH;

  step_t            step;
  step_t            step_next;
  ctrl_t            cw;
  logic             cond_true;
  logic             act;
  logic [W-1:0]     n;
  logic [W-1:0]     d;
  logic [COUNT_W-1:0] count;
  logic [W+31:0]    value_ext;
  logic             div_start;
  logic             div_busy;
  logic [W-1:0]     div_q;
  logic [W-1:0]     div_r;
  logic             out_full;

  assign value_ext = {{W{1'b0}}, value};
  assign out_full  = out_valid && !out_ready;
  assign cw        = ucode(step);

  always_comb begin
    unique case (cw.cond)
      C_NEVER:    cond_true = 1'b0;
      C_ALWAYS:   cond_true = 1'b1;
      C_IN_NONE:  cond_true = !in_valid;
      C_N_LT2:    cond_true = n < W'(2);
      C_N_ODD:    cond_true = n[0];
      C_N1_ZERO:  cond_true = !n[1];
      C_DIV_BUSY: cond_true = div_busy;
      C_D_GT_Q:   cond_true = d > div_q;
      C_R_NZ:     cond_true = div_r != '0;
      C_R_ZERO:   cond_true = div_r == '0;
      C_OUT_FULL: cond_true = out_full;
      default:    cond_true = 1'b0;
    endcase
    act       = !(cw.gated && cond_true);
    step_next = cond_true ? cw.target : step + 1'b1;
    div_start = act && (cw.op == OP_START);
  end

  assign in_ready = (step == S_IDLE);

  dpfc_div #(.W(W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (n),
    .divisor   (d),
    .busy      (div_busy),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      step <= step_next;
      if (act && cw.op == OP_PUBLISH) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (act && cw.inc) begin
      count <= count + 1'b1;
    end
    if (act) begin
      unique case (cw.op)
        OP_LOAD: begin
          n     <= value_ext[W-1:0];
          d     <= W'(3);
          count <= '0;
        end
        OP_HALVE:   n <= {1'b0, n[W-1:1]};
        OP_TAKE_Q:  n <= div_q;
        OP_NEXT_D:  d <= d + W'(2);
        OP_PUBLISH: prime_count <= count;
        OP_NONE, OP_START: ;
        default: ;
      endcase
    end
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

  import dpfc_pkg::*;

  localparam int QUIET_LIMIT = 200000;
  localparam int TAIL_ITEMS  = 20;
  localparam int RANDOM_ITEMS = 80;

  typedef struct {
    logic [31:0]        value;
    logic [COUNT_W-1:0] count;
  } factor_check_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [31:0]        value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [COUNT_W-1:0] prime_count;

  logic [31:0]   pending_values[$];
  factor_check_t expected_counts[$];
  int            accepted_count = 0;
  int            quiet_from = 0;
  int            mismatch_count = 0;
  int            send_gap = 0;
  int            recv_stall = 0;
  int            quiet_cycles = 0;

  distinct_prime_factor_count dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .prime_count(prime_count)
  );

  always #1 clk = ~clk;

  function automatic logic [COUNT_W-1:0] count_prime_divisors(input logic [31:0] v);
    longint unsigned n;
    longint unsigned d;
    int unsigned     found;
    n = v;
    found = 0;
    if (n < 2) return '0;
    if ((n & 1) == 0) begin
      found++;
      while ((n & 1) == 0) n = n >> 1;
    end
    for (d = 3; d <= n / d; d += 2) begin
      if (n % d == 0) begin
        found++;
        while (n % d == 0) n = n / d;
      end
    end
    if (n > 1) found++;
    return found[COUNT_W-1:0];
  endfunction

  // Values are kept cheap for the divider: smooth products, a modest odd part
  // pushed up by a power of two, or tiny values.
  function automatic logic [31:0] random_value();
    longint unsigned v;
    int unsigned     f;
    int unsigned     kind;
    int unsigned     s;
    logic            done;
    kind = $urandom_range(0, 9);
    done = 1'b0;
    if (kind < 4) begin
      v = 1;
      do begin
        f = $urandom_range(2, 97);
        if (v * f <= 64'hFFFF_FFFF) v = v * f;
        else done = 1'b1;
      end while (!done && $urandom_range(0, 7) != 0);
    end else if (kind < 8) begin
      v = $urandom_range(1, (1 << 18) - 1);
    end else begin
      v = $urandom_range(0, 255);
    end
    if (v != 0 && kind < 8) begin
      s = 0;
      while (s < 31 && (v << (s + 1)) <= 64'hFFFF_FFFF) s++;
      v = v << $urandom_range(0, s);
    end
    return v[31:0];
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH: %s", msg);
  endtask

  // driver
  always @(posedge clk) begin : drive
    logic        next_valid;
    logic [31:0] next_value;
    factor_check_t entry;
    next_valid = in_valid;
    next_value = value;
    if (rst) begin
      next_valid = 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        entry.value = value;
        entry.count = count_prime_divisors(value);
        expected_counts.push_back(entry);
        accepted_count++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_values.size() > 0) begin
          next_value = pending_values.pop_front();
          next_valid = 1'b1;
          if (accepted_count < quiet_from && $urandom_range(0, 3) == 0)
            send_gap = $urandom_range(1, 16);
        end
      end
    end
    in_valid <= next_valid;
    value    <= next_value;
  end

  // monitor
  always @(posedge clk) begin : collect
    factor_check_t want;
    if (rst) begin
      out_ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_counts.size() == 0) begin
          report_mismatch($sformatf("prime_count %0d with no transaction pending",
                                    prime_count));
        end else begin
          want = expected_counts.pop_front();
          if (prime_count !== want.count)
            report_mismatch($sformatf("value %0d: prime_count %0d, expected %0d",
                                      want.value, prime_count, want.count));
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else if (accepted_count < quiet_from && $urandom_range(0, 4) == 0) begin
        recv_stall = $urandom_range(1, 16) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on forward progress
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // zero, one, primes, prime powers, the nine-prime primorial, all-ones
    pending_values = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd9, 32'd12, 32'd30,
                       32'd97, 32'd65521, 32'd65537, 32'd196563, 32'd999983,
                       32'd223092870, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_0000,
                       32'hAAAA_AAAA, 32'h5555_5555, 32'd1048576};
    for (int i = 0; i < RANDOM_ITEMS; i++) pending_values.push_back(random_value());
    quiet_from = pending_values.size() - TAIL_ITEMS;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pending_values.size() != 0 || in_valid || expected_counts.size() != 0)
      @(negedge clk);
    repeat (64) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/dpfc_pkg.sv
src/dpfc_div.sv
src/distinct_prime_factor_count.sv
bench/tb.sv
